### sv/cob_pkg.sv
// Shared constants, types and helpers for the cursor overlay blend.
// No dependencies; compiled before every other file of the block.
package cob_pkg;

	localparam int CURSOR_MAX_DIM = 64;
	localparam int DIM_W          = $clog2(CURSOR_MAX_DIM);
	localparam int CW_W           = $clog2(CURSOR_MAX_DIM + 1);
	localparam int STORE_DEPTH    = CURSOR_MAX_DIM * CURSOR_MAX_DIM;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int LIM_W          = 2 * CW_W;
	localparam int PROD_W         = DIM_W + CW_W;

	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 15;

	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	typedef struct packed {
		logic              is_pixel;
		logic              hit;
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} cob_entry_t;

	function automatic logic [CW_W-1:0] sat_dim(input logic [6:0] v);
		if (int'(v) > CURSOR_MAX_DIM) begin
			return CW_W'(CURSOR_MAX_DIM);
		end
		return CW_W'(v);
	endfunction

	// x / 255 for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'd1 + 17'(x[15:8]);
		return s[15:8];
	endfunction

endpackage

### sv/cob_if.sv
// Channel interfaces of the cursor overlay blend: item, result and register write.
// Depends on cob_pkg.
interface cob_item_if import cob_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] cursor_word;
	logic [7:0]  pixel_blue;
	logic [7:0]  pixel_green;
	logic [7:0]  pixel_red;
	logic [7:0]  pixel_extra;

	modport source (output valid, cmd, cursor_word, pixel_blue, pixel_green, pixel_red,
		pixel_extra, input ready);
	modport sink (input valid, cmd, cursor_word, pixel_blue, pixel_green, pixel_red,
		pixel_extra, output ready);
endinterface

interface cob_result_if import cob_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [7:0] out_extra;
	logic       frame_last;

	modport source (output valid, out_blue, out_green, out_red, out_extra, frame_last,
		input ready);
	modport sink (input valid, out_blue, out_green, out_red, out_extra, frame_last,
		output ready);
endinterface

interface cob_cfg_if import cob_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/cob_front.sv
// Front end: registers, item acceptance, frame position and cursor address.
// Depends on cob_pkg and cob_if; feeds cob_queue.
module cob_front import cob_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cob_item_if.sink   item,
	cob_cfg_if.sink    cfg,
	input  logic       q_full,
	output logic       q_push,
	output cob_entry_t q_entry
);

	logic signed [14:0] cursor_x_q;
	logic signed [14:0] cursor_y_q;
	logic [6:0]         cursor_width_q;
	logic [6:0]         cursor_height_q;
	logic [13:0]        image_width_q;
	logic [13:0]        image_height_q;

	logic [ADDR_W-1:0]  load_index_q;
	logic [13:0]        column_q;
	logic [13:0]        row_q;

	logic               v_s1;
	logic               is_pixel_s1;
	logic               hit_s1;
	logic               last_s1;
	logic [DIM_W-1:0]   ci_s1;
	logic [DIM_W-1:0]   cj_s1;
	logic [ADDR_W-1:0]  laddr_s1;
	logic [31:0]        data_s1;

	logic [CW_W-1:0]    cw;
	logic [CW_W-1:0]    ch;
	logic               accept;
	logic signed [16:0] ci;
	logic signed [16:0] cj;
	logic               hit;
	logic               last_col;
	logic               last_row;
	logic [LIM_W-1:0]   limit;
	logic [LIM_W-1:0]   load_next;
	logic [PROD_W-1:0]  paddr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q      <= '0;
			cursor_y_q      <= '0;
			cursor_width_q  <= '0;
			cursor_height_q <= '0;
			image_width_q   <= '0;
			image_height_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CURSOR_X:      cursor_x_q      <= cfg.data[14:0];
				REG_CURSOR_Y:      cursor_y_q      <= cfg.data[14:0];
				REG_CURSOR_WIDTH:  cursor_width_q  <= cfg.data[6:0];
				REG_CURSOR_HEIGHT: cursor_height_q <= cfg.data[6:0];
				REG_IMAGE_WIDTH:   image_width_q   <= cfg.data[13:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg.data[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cw        = sat_dim(cursor_width_q);
		ch        = sat_dim(cursor_height_q);
		accept    = item.valid && item.ready;
		ci        = $signed({3'b000, column_q}) - 17'(cursor_x_q);
		cj        = $signed({3'b000, image_height_q}) - 17'sd1 - 17'(cursor_y_q)
			- $signed({3'b000, row_q});
		hit       = !ci[16] && (ci[15:0] < 16'(cw)) && !cj[16] && (cj[15:0] < 16'(ch));
		last_col  = (15'(column_q) + 15'd1) >= 15'(image_width_q);
		last_row  = (15'(row_q) + 15'd1) >= 15'(image_height_q);
		limit     = LIM_W'(cw) * LIM_W'(ch);
		if (limit == '0) begin
			limit = LIM_W'(STORE_DEPTH);
		end
		load_next = LIM_W'(load_index_q) + LIM_W'(1);
		paddr     = PROD_W'(cj_s1) * PROD_W'(cw) + PROD_W'(ci_s1);
	end

	assign item.ready = !v_s1 || !q_full;
	assign q_push     = v_s1 && !q_full;

	always_comb begin
		q_entry.is_pixel = is_pixel_s1;
		q_entry.hit      = hit_s1;
		q_entry.last     = last_s1;
		q_entry.addr     = is_pixel_s1 ? paddr[ADDR_W-1:0] : laddr_s1;
		q_entry.data     = data_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			load_index_q <= '0;
			column_q     <= '0;
			row_q        <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (q_push) begin
				v_s1 <= 1'b0;
			end
			if (accept && item.cmd == CMD_LOAD) begin
				load_index_q <= (load_next >= limit) ? '0 : load_next[ADDR_W-1:0];
			end
			if (accept && item.cmd == CMD_PIXEL) begin
				if (last_col) begin
					column_q <= '0;
					row_q    <= last_row ? '0 : row_q + 14'd1;
				end else begin
					column_q <= column_q + 14'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_pixel_s1 <= item.cmd == CMD_PIXEL;
			hit_s1      <= hit;
			last_s1     <= last_col && last_row;
			ci_s1       <= ci[DIM_W-1:0];
			cj_s1       <= cj[DIM_W-1:0];
			laddr_s1    <= load_index_q;
			data_s1     <= (item.cmd == CMD_LOAD) ? item.cursor_word
				: {item.pixel_extra, item.pixel_red, item.pixel_green, item.pixel_blue};
		end
	end

endmodule

### sv/cob_queue.sv
// Short first-in first-out queue between the front and back ends.
// Depends on cob_pkg.
module cob_queue import cob_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cob_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output cob_entry_t pop_data,
	output logic       empty
);

	cob_entry_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/cob_back.sv
// Back end: cursor store, alpha blend pipeline and result register.
// Depends on cob_pkg and cob_if; drained from cob_queue.
module cob_back import cob_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cob_entry_t q_entry,
	output logic       q_pop,
	cob_result_if.source result
);

	logic [31:0] store_mem [STORE_DEPTH];

	logic        v_s1;
	logic        hit_s1;
	logic        last_s1;
	logic [31:0] pix_s1;
	logic [31:0] cur_s1;

	logic        v_s2;
	logic        hit_s2;
	logic        last_s2;
	logic [31:0] pix_s2;
	logic [23:0] col_s2;
	logic [15:0] prod_s2 [3];

	logic        v_s3;
	logic        last_s3;
	logic [31:0] pix_s3;

	logic        adv;
	logic [7:0]  inv_a;
	logic [15:0] prod [3];
	logic [23:0] blend;

	assign adv   = !v_s3 || result.ready;
	assign q_pop = adv && !q_empty;
	assign inv_a = ~cur_s1[31:24];

	always_ff @(posedge clk) begin
		if (q_pop && !q_entry.is_pixel) begin
			store_mem[q_entry.addr] <= q_entry.data;
		end
		if (q_pop && q_entry.is_pixel) begin
			cur_s1 <= store_mem[q_entry.addr];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = 16'(pix_s1[8*k +: 8]) * 16'(inv_a) + 16'd127;
		end
		for (int k = 0; k < 3; k++) begin
			blend[8*k +: 8] = hit_s2 ? div255(prod_s2[k]) + col_s2[8*k +: 8]
				: pix_s2[8*k +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_pop && q_entry.is_pixel;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1  <= q_entry.hit;
			last_s1 <= q_entry.last;
			pix_s1  <= q_entry.data;
			hit_s2  <= hit_s1;
			last_s2 <= last_s1;
			pix_s2  <= pix_s1;
			col_s2  <= cur_s1[23:0];
			prod_s2 <= prod;
			last_s3 <= last_s2;
			pix_s3  <= {pix_s2[31:24], blend};
		end
	end

	assign result.valid      = v_s3;
	assign result.out_blue   = pix_s3[7:0];
	assign result.out_green  = pix_s3[15:8];
	assign result.out_red    = pix_s3[23:16];
	assign result.out_extra  = pix_s3[31:24];
	assign result.frame_last = last_s3;

endmodule

### sv/cursor_overlay_blend.sv
// Cursor overlay blend, top level: front end, queue and back end.
// Depends on cob_pkg, cob_if, cob_front, cob_queue and cob_back.
//
//   channel  role   transfer carries
//   item     sink   cmd, cursor_word, pixel_blue/green/red/extra
//   result   source out_blue/green/red/extra, frame_last
//   cfg      sink   index, data (register write, always ready)
//
// One item per cycle sustained while result does not stall; a pixel reaches result
// through the front register, queue slot, store read, multiply, then divide and add.
// A cursor load yields no result and retires at the store write port.
// Reset clears counters, registers and valid flags; cursor store contents are undefined.
// A stalled result freezes the back end; the queue holds four entries and the front
// register one more before item stalls.
module cursor_overlay_blend import cob_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	cob_item_if.sink     item,
	cob_result_if.source result,
	cob_cfg_if.sink      cfg
);

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	cob_entry_t q_in;
	cob_entry_t q_out;

	cob_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_in)
	);

	cob_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	cob_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_entry (q_out),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule
